FILE: hw/rtl/hnm_pkg.sv
// Shared types and constants for the height-to-normal-map block.
// Used by the top level and the port checker.
package hnm_pkg;

    localparam int unsigned LUM_W      = 24;
    localparam int unsigned POS_W      = 9;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SIZE_REG_W = 10;
    localparam int unsigned SCALE_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Q16 luminance weights; they sum to 65536.
    localparam logic [15:0] WEIGHT_R = 16'd13933;
    localparam logic [15:0] WEIGHT_G = 16'd46871;
    localparam logic [15:0] WEIGHT_B = 16'd4732;

    localparam logic [SIZE_REG_W-1:0] SIZE_RESET  = 10'd512;
    localparam logic [SCALE_W-1:0]    SCALE_RESET = 16'd2560;

    // Datapath widths: gradients, squared sum, root and divider numerators.
    localparam int unsigned GRAD_W = 24;
    localparam int unsigned PROD_W = 48;
    localparam int unsigned SUM_W  = 50;
    localparam int unsigned ROOT_W = 26;
    localparam int unsigned NUM_W  = 34;

    // z term 2*65280 and its square.
    localparam logic [ROOT_W-1:0] Z_TERM = 26'd130560;
    localparam logic [SUM_W-1:0]  Z_SQ   = 50'd17045913600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_HEIGHT_SCALE = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_COMPUTE = 1'b1
    } t_action;

    typedef struct packed {
        logic              action;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] normal_x;
        logic [BYTE_W-1:0] normal_y;
        logic [BYTE_W-1:0] normal_z;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
    } t_out_item;

    function automatic logic [LUM_W-1:0] luminance(input logic [BYTE_W-1:0] r,
                                                   input logic [BYTE_W-1:0] g,
                                                   input logic [BYTE_W-1:0] b);
        logic [LUM_W:0] acc;
        acc = (LUM_W+1)'(WEIGHT_R) * (LUM_W+1)'(r) + (LUM_W+1)'(WEIGHT_G) * (LUM_W+1)'(g)
            + (LUM_W+1)'(WEIGHT_B) * (LUM_W+1)'(b);
        return acc[LUM_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/hnm_store.sv
// Single-port synchronous luminance store with a registered read port.
// Depends on nothing but its parameters.
module hnm_store #(
    parameter int ADDR_W = 18,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/height_to_normal_map_top.sv
// Top level of the height-to-normal-map block: sequencer and arithmetic.
// Depends on hnm_pkg and hnm_store.
//
// A load item has its luminance written into the store at the accepting edge,
// and busy stays low. A compute item inside the image keeps busy high through
// four neighbor reads from the single-port store,
// four passes through one shared 24x24 multiplier, a 25-step bit-pair square
// root and three 8-step restoring dividers running side by side. The result
// appears for one cycle with o_result_valid while busy is still high; the
// next item is taken in the cycle after. A compute outside the image gives
// no result and busy stays low. Results cannot be stalled.
module height_to_normal_map_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  hnm_pkg::t_in_item                 i_item,
    output logic                              busy,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hnm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_result_valid,
    output hnm_pkg::t_out_item                o_result
);
    import hnm_pkg::*;

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = CW + RW;
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SZ_W   = $clog2(MAX_DIM + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_L, ST_RD_R, ST_RD_U, ST_RD_D, ST_MUL_A, ST_MUL_B,
        ST_SQ_A, ST_SQ_B, ST_SUM, ST_SQRT, ST_PREP, ST_DIV, ST_OUT
    } t_state;

    function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v,
                                                   input int unsigned maxv);
        logic [SZ_W-1:0] res;
        if (v == '0) begin
            res = SZ_W'(1);
        end else if (32'(v) > maxv) begin
            res = SZ_W'(maxv);
        end else begin
            res = SZ_W'(v);
        end
        return res;
    endfunction

    t_state             r_state;
    logic [SZ_W-1:0]    r_width, r_height;
    logic [SCALE_W-1:0] r_scale;
    logic [POS_W-1:0]   r_row, r_col;
    logic [CW-1:0]      r_col_a, r_cl, r_cr;
    logic [RW-1:0]      r_row_a, r_ru, r_rd;
    logic [LUM_W-1:0]   r_yl, r_yr, r_yu, r_yd;
    logic [PROD_W-1:0]  r_prod;
    logic [GRAD_W-1:0]  r_amag, r_bmag;
    logic               r_sa, r_sb;
    logic [SUM_W-1:0]   r_sum, r_res, r_bit;
    logic [NUM_W-1:0]   r_rem_x, r_rem_y, r_rem_z, r_dsh;
    logic [BYTE_W-1:0]  r_qx, r_qy, r_qz;
    logic [2:0]         r_cnt;

    logic               accept;
    logic               in_image;
    logic [SZ_W-1:0]    col_s, row_s, cl_s, cr_s, ru_s, rd_s;
    logic               st_we;
    logic [ADDR_W-1:0]  st_addr;
    logic [LUM_W-1:0]   st_rdata;
    logic [LUM_W-1:0]   diff_x;
    logic [GRAD_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [SUM_W-1:0]   sq_try;
    logic [ROOT_W-1:0]  root, px, py, pz;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign col_s    = SZ_W'(i_item.col);
    assign row_s    = SZ_W'(i_item.row);
    assign in_image = (32'(i_item.row) < 32'(r_height)) && (32'(i_item.col) < 32'(r_width));
    assign cl_s     = (col_s == '0) ? r_width - SZ_W'(1) : col_s - SZ_W'(1);
    assign cr_s     = (col_s + SZ_W'(1) == r_width) ? '0 : col_s + SZ_W'(1);
    assign ru_s     = (row_s == '0) ? r_height - SZ_W'(1) : row_s - SZ_W'(1);
    assign rd_s     = (row_s + SZ_W'(1) == r_height) ? '0 : row_s + SZ_W'(1);

    // Loads outside the store are dropped.
    assign st_we = accept && (i_item.action == ACT_LOAD)
                && (32'(i_item.row) < MAX_HEIGHT) && (32'(i_item.col) < MAX_WIDTH);

    always_comb begin
        case (r_state)
            ST_RD_L: st_addr = {r_row_a, r_cl};
            ST_RD_R: st_addr = {r_row_a, r_cr};
            ST_RD_U: st_addr = {r_ru, r_col_a};
            ST_RD_D: st_addr = {r_rd, r_col_a};
            default: st_addr = {RW'(i_item.row), CW'(i_item.col)};
        endcase
    end

    hnm_store #(.ADDR_W(ADDR_W), .DATA_W(LUM_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_addr  (st_addr),
        .i_wdata (luminance(i_item.red, i_item.green, i_item.blue)),
        .o_rdata (st_rdata)
    );

    assign diff_x = (r_yr >= r_yl) ? r_yr - r_yl : r_yl - r_yr;

    // One shared multiplier for both gradients and both squares.
    always_comb begin
        case (r_state)
            ST_MUL_A: begin
                mul_a = diff_x;
                mul_b = GRAD_W'(r_scale);
            end
            ST_MUL_B: begin
                mul_a = GRAD_W'(r_yd >= r_yu ? r_yd - r_yu : r_yu - r_yd);
                mul_b = GRAD_W'(r_scale);
            end
            ST_SQ_A: begin
                mul_a = r_amag;
                mul_b = r_amag;
            end
            default: begin
                mul_a = r_bmag;
                mul_b = r_bmag;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign sq_try = r_res + r_bit;
    assign root   = r_res[ROOT_W-1:0];
    assign px     = r_sa ? root + ROOT_W'(r_amag) : root - ROOT_W'(r_amag);
    assign py     = r_sb ? root + ROOT_W'(r_bmag) : root - ROOT_W'(r_bmag);
    assign pz     = root + Z_TERM;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_width  <= clamp_size(SIZE_RESET, MAX_WIDTH);
            r_height <= clamp_size(SIZE_RESET, MAX_HEIGHT);
            r_scale  <= SCALE_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= clamp_size(i_cfg_data[SIZE_REG_W-1:0],
                                                             MAX_WIDTH);
                    CFG_IMAGE_HEIGHT: r_height <= clamp_size(i_cfg_data[SIZE_REG_W-1:0],
                                                             MAX_HEIGHT);
                    CFG_HEIGHT_SCALE: r_scale  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_item.action == ACT_COMPUTE) && in_image) begin
                        r_row   <= i_item.row;
                        r_col   <= i_item.col;
                        r_row_a <= RW'(i_item.row);
                        r_col_a <= CW'(i_item.col);
                        r_cl    <= CW'(cl_s);
                        r_cr    <= CW'(cr_s);
                        r_ru    <= RW'(ru_s);
                        r_rd    <= RW'(rd_s);
                        r_state <= ST_RD_L;
                    end
                end
                ST_RD_L: r_state <= ST_RD_R;
                ST_RD_R: begin
                    r_yl    <= st_rdata;
                    r_state <= ST_RD_U;
                end
                ST_RD_U: begin
                    r_yr    <= st_rdata;
                    r_state <= ST_RD_D;
                end
                ST_RD_D: begin
                    r_yu    <= st_rdata;
                    r_state <= ST_MUL_A;
                end
                ST_MUL_A: begin
                    r_yd    <= st_rdata;
                    r_sa    <= (r_yr < r_yl);
                    r_prod  <= mul_p;
                    r_state <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_amag  <= r_prod[GRAD_W+15:16];
                    r_sb    <= (r_yd < r_yu);
                    r_prod  <= mul_p;
                    r_state <= ST_SQ_A;
                end
                ST_SQ_A: begin
                    r_bmag  <= r_prod[GRAD_W+15:16];
                    r_prod  <= mul_p;
                    r_state <= ST_SQ_B;
                end
                ST_SQ_B: begin
                    r_sum   <= SUM_W'(r_prod) + Z_SQ;
                    r_prod  <= mul_p;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_sum   <= r_sum + SUM_W'(r_prod);
                    r_res   <= '0;
                    r_bit   <= SUM_W'(1) << (SUM_W - 2);
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    // One result bit is settled per step from a pair of radicand bits, top pair first.
                    if (r_sum >= sq_try) begin
                        r_sum <= r_sum - sq_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_rem_x <= (NUM_W'(px) << 8) - NUM_W'(px);
                    r_rem_y <= (NUM_W'(py) << 8) - NUM_W'(py);
                    r_rem_z <= (NUM_W'(pz) << 8) - NUM_W'(pz);
                    r_dsh   <= NUM_W'(root) << 8;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // Quotients fit in eight bits, so eight restoring steps suffice.
                    if (r_rem_x >= r_dsh) r_rem_x <= r_rem_x - r_dsh;
                    if (r_rem_y >= r_dsh) r_rem_y <= r_rem_y - r_dsh;
                    if (r_rem_z >= r_dsh) r_rem_z <= r_rem_z - r_dsh;
                    r_qx  <= {r_qx[BYTE_W-2:0], r_rem_x >= r_dsh};
                    r_qy  <= {r_qy[BYTE_W-2:0], r_rem_y >= r_dsh};
                    r_qz  <= {r_qz[BYTE_W-2:0], r_rem_z >= r_dsh};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT:  r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_result_valid    = (r_state == ST_OUT);
    assign o_result.normal_x = r_qx;
    assign o_result.normal_y = r_qy;
    assign o_result.normal_z = r_qz;
    assign o_result.out_row  = r_row;
    assign o_result.out_col  = r_col;
endmodule

FILE: hw/rtl/hnm_check.sv
// Port-level checker for height_to_normal_map_top, with its bind statement.
// Depends on hnm_pkg.
module hnm_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input hnm_pkg::t_in_item              i_item,
    input logic                           busy,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic                           o_result_valid
);
    import hnm_pkg::*;

    // Registers are to be written only while no item is in work; the block does not enforce it.
    a_cfg_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !busy)
        else $error("register written while an item is in work");

    // The block frees up right after showing a result, and shows it once.
    a_result_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> (!busy && !o_result_valid))
        else $error("result not followed by idle");

    // A load item never occupies the block.
    a_load_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.action == ACT_LOAD)) |=> !busy)
        else $error("load item left the block busy");

    // Work begins only from an accepted compute item.
    a_busy_from_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ($past(start) && ($past(i_item.action) == ACT_COMPUTE)))
        else $error("busy rose without a compute item");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_valid))
        else $error("block not idle after reset");
endmodule

bind height_to_normal_map_top hnm_check u_hnm_check (.*);
